/* hdl/gas_pkg.sv */
// Shared types, constants and helpers for the graph adjacency store.
// Used by graph_adjacency_store and its testbench; depends on nothing else.
package gas_pkg;

    localparam int MAX_NODES = 64;
    localparam int SLOT_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    // degree never exceeds MAX_NODES-1
    localparam int DEG_W     = SLOT_W;
    localparam int ID_W      = 64;
    localparam int MODE_W    = 3;
    localparam int OUT_DEG_W = 6;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ADD_NODE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL_NODE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET_NODE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_EDGE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GET_EDGE = 3'd5;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_PRESENT     = 3'd1,
        ST_BAD         = 3'd2,
        ST_NODE_FOUND  = 3'd3,
        ST_NODE_ABSENT = 3'd4,
        ST_EDGE_FOUND  = 3'd5,
        ST_EDGE_ABSENT = 3'd6,
        ST_FULL        = 3'd7
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   second_id;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [OUT_DEG_W-1:0] first_degree;
    } t_rsp;

    // one adjacency memory word: neighbor count and matrix row
    typedef struct packed {
        logic [DEG_W-1:0]     deg;
        logic [MAX_NODES-1:0] row;
    } t_adj_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_RD_A,
        S_LATCH_A,
        S_DECIDE,
        S_RD_B,
        S_WR_B,
        S_WR_A,
        S_RM_SCAN,
        S_RM_WR,
        S_RM_FREE,
        S_DONE
    } t_state;

    // saturate an internal degree to the result field
    function automatic logic [OUT_DEG_W-1:0] sat_deg(input logic [DEG_W-1:0] d);
        logic [31:0] wide;
        wide = 32'(d);
        if (wide > 32'((1 << OUT_DEG_W) - 1)) begin
            sat_deg = '1;
        end else begin
            sat_deg = OUT_DEG_W'(wide);
        end
    endfunction

endpackage

/* hdl/gas_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
module gas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

/* hdl/graph_adjacency_store.sv */
// Graph adjacency store: node ids and an adjacency bit matrix with degrees.
// Node adds, lookups and rejected requests scan the id RAM, one slot a cycle, then
// read the first node's row and decide; an edge add or remove that changes the
// matrix then rewrites the second node's row and the first's. Node removal sweeps
// all rows and clears the removed node from each neighbor's row. Throughput:
// one transaction in flight, the next is accepted the cycle after the result loads.
// Reset (synchronous, i_rst_n low) clears valid bits and control; RAM rows are
// rewritten when a slot is claimed, so no clearing pass is needed.
module graph_adjacency_store
    import gas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_NODES - 1);

    t_state r_state, n_state;

    t_req                 r_req;
    logic [MAX_NODES-1:0] r_valid;
    logic [SLOT_W-1:0]    r_idx;
    logic                 r_cmp_vld;
    logic [SLOT_W-1:0]    r_cmp_idx;
    logic                 r_fa, r_fb, r_ffree;
    logic [SLOT_W-1:0]    r_sa, r_sb, r_sfree;
    logic [MAX_NODES-1:0] r_row_a;
    logic [DEG_W-1:0]     r_deg_a;
    logic                 r_set;
    t_status              r_status;
    logic [OUT_DEG_W-1:0] r_deg_out;
    logic                 r_out_valid;
    t_rsp                 r_out;

    // RAM ports
    logic              id_we;
    logic [SLOT_W-1:0] id_raddr;
    logic [ID_W-1:0]   id_rdata;
    logic              adj_we;
    logic [SLOT_W-1:0] adj_waddr, adj_raddr;
    t_adj_word         adj_wdata, adj_rdata;

    gas_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (r_sfree),
        .i_wdata (r_req.first_id),
        .i_raddr (id_raddr),
        .o_rdata (id_rdata)
    );

    gas_ram #(.WIDTH($bits(t_adj_word)), .DEPTH(MAX_NODES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    logic accept;
    logic edge_bit;
    logic ids_equal;
    assign accept    = i_req_valid && (r_state == S_IDLE);
    assign edge_bit  = r_row_a[r_sb];
    assign ids_equal = (r_req.first_id == r_req.second_id);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and RAM controls
    always_comb begin
        n_state   = r_state;
        id_we     = 1'b0;
        id_raddr  = r_idx;
        adj_we    = 1'b0;
        adj_waddr = r_sa;
        adj_wdata = '0;
        adj_raddr = r_sa;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == LAST_SLOT) n_state = S_SCAN_END;
            end
            S_SCAN_END: n_state = S_RD_A;
            S_RD_A:     n_state = S_LATCH_A;
            S_LATCH_A:  n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_req.mode)
                    MODE_ADD_NODE: begin
                        if (!r_fa && r_ffree) begin
                            id_we     = 1'b1;
                            adj_we    = 1'b1;
                            adj_waddr = r_sfree;
                        end
                    end
                    MODE_DEL_NODE: begin
                        if (r_fa) n_state = S_RM_SCAN;
                    end
                    MODE_ADD_EDGE: begin
                        if (!ids_equal && r_fa && r_fb && !edge_bit) n_state = S_RD_B;
                    end
                    MODE_DEL_EDGE: begin
                        if (!ids_equal && r_fa && r_fb && edge_bit) n_state = S_RD_B;
                    end
                    default: ;
                endcase
            end
            S_RD_B: begin
                adj_raddr = r_sb;
                n_state   = S_WR_B;
            end
            S_WR_B: begin
                adj_we    = 1'b1;
                adj_waddr = r_sb;
                adj_wdata = adj_rdata;
                adj_wdata.row[r_sa] = r_set;
                if (r_set) begin
                    adj_wdata.deg = adj_rdata.deg + 1'b1;
                end else if (adj_rdata.deg != '0) begin
                    adj_wdata.deg = adj_rdata.deg - 1'b1;
                end
                n_state = S_WR_A;
            end
            S_WR_A: begin
                adj_we    = 1'b1;
                adj_waddr = r_sa;
                adj_wdata.row = r_row_a;
                adj_wdata.row[r_sb] = r_set;
                adj_wdata.deg = r_deg_a;
                n_state = S_DONE;
            end
            S_RM_SCAN: begin
                adj_raddr = r_idx;
                if (r_row_a[r_idx] && r_valid[r_idx]) begin
                    n_state = S_RM_WR;
                end else if (r_idx == LAST_SLOT) begin
                    n_state = S_RM_FREE;
                end
            end
            S_RM_WR: begin
                adj_we    = 1'b1;
                adj_waddr = r_idx;
                adj_wdata = adj_rdata;
                adj_wdata.row[r_sa] = 1'b0;
                if (adj_rdata.deg != '0) adj_wdata.deg = adj_rdata.deg - 1'b1;
                n_state = (r_idx == LAST_SLOT) ? S_RM_FREE : S_RM_SCAN;
            end
            S_RM_FREE: begin
                adj_we    = 1'b1;
                adj_waddr = r_sa;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_rsp_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // request capture, id scan and result bookkeeping
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_cmp_idx <= r_idx;
        if (r_cmp_vld) begin
            if (r_valid[r_cmp_idx] && id_rdata == r_req.first_id) begin
                r_fa <= 1'b1;
                r_sa <= r_cmp_idx;
            end
            if (r_valid[r_cmp_idx] && id_rdata == r_req.second_id) begin
                r_fb <= 1'b1;
                r_sb <= r_cmp_idx;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_idx   <= '0;
                r_fa    <= 1'b0;
                r_fb    <= 1'b0;
                r_ffree <= 1'b0;
            end
            S_SCAN: begin
                if (!r_valid[r_idx] && !r_ffree) begin
                    r_ffree <= 1'b1;
                    r_sfree <= r_idx;
                end
                if (r_idx != LAST_SLOT) r_idx <= r_idx + 1'b1;
            end
            S_LATCH_A: begin
                r_row_a <= adj_rdata.row;
                r_deg_a <= adj_rdata.deg;
            end
            S_DECIDE: begin
                r_idx     <= '0;
                r_status  <= ST_BAD;
                r_deg_out <= r_fa ? sat_deg(r_deg_a) : '0;
                case (r_req.mode)
                    MODE_ADD_NODE: begin
                        if (r_fa) begin
                            r_status <= ST_PRESENT;
                        end else if (!r_ffree) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                    MODE_DEL_NODE: begin
                        r_status <= r_fa ? ST_OK : ST_BAD;
                    end
                    MODE_GET_NODE: begin
                        r_status <= r_fa ? ST_NODE_FOUND : ST_NODE_ABSENT;
                    end
                    MODE_ADD_EDGE: begin
                        r_set <= 1'b1;
                        if (!ids_equal && r_fa && r_fb) begin
                            r_status <= edge_bit ? ST_PRESENT : ST_OK;
                        end
                    end
                    MODE_DEL_EDGE: begin
                        r_set <= 1'b0;
                        if (!ids_equal && r_fa && r_fb && edge_bit) r_status <= ST_OK;
                    end
                    MODE_GET_EDGE: begin
                        if (!ids_equal && r_fa && r_fb) begin
                            r_status <= edge_bit ? ST_EDGE_FOUND : ST_EDGE_ABSENT;
                        end
                    end
                    default: ;
                endcase
            end
            S_RD_B: begin
                // new degree of the first node
                if (r_set) begin
                    r_deg_a <= r_deg_a + 1'b1;
                end else if (r_deg_a != '0) begin
                    r_deg_a <= r_deg_a - 1'b1;
                end
            end
            S_WR_A: begin
                r_deg_out <= sat_deg(r_deg_a);
            end
            S_RM_SCAN: begin
                if (!(r_row_a[r_idx] && r_valid[r_idx]) && r_idx != LAST_SLOT) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_RM_WR: begin
                if (r_idx != LAST_SLOT) r_idx <= r_idx + 1'b1;
            end
            S_RM_FREE: begin
                r_deg_out <= '0;
            end
            default: ;
        endcase
    end

    // control registers: compare pipe, slot valid bits, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == S_SCAN);
            if (r_state == S_DECIDE && r_req.mode == MODE_ADD_NODE && !r_fa && r_ffree) begin
                r_valid[r_sfree] <= 1'b1;
            end
            if (r_state == S_RM_FREE) begin
                r_valid[r_sa] <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || !i_rsp_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_rsp_stall)) begin
            r_out.status       <= r_status;
            r_out.first_degree <= r_deg_out;
        end
    end
endmodule

/* dv/tb_graph_adjacency_store.sv */
// Self-checking testbench for graph_adjacency_store: directed table, a fill and hub
// phase, then random node/edge traffic checked against an in-bench graph predictor.
// Depends on gas_pkg and graph_adjacency_store.
`timescale 1ns / 100ps

module tb_graph_adjacency_store;
    import gas_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int N_RANDOM    = 1000;
    localparam logic [63:0] ID_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    graph_adjacency_store uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
    );

    // predictor state
    logic [63:0]          g_ids   [MAX_NODES];
    logic                 g_valid [MAX_NODES];
    logic [MAX_NODES-1:0] g_adj   [MAX_NODES];
    int                   g_deg   [MAX_NODES];
    int                   g_count;

    t_rsp        rsp_queue[$];
    int          err_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [63:0] id_pool[16];

    // one directed row; check_fixed selects the typed-in expectation
    typedef struct {
        logic [2:0]  mode;
        logic [63:0] a;
        logic [63:0] b;
        bit          check_fixed;
        t_status     status;
        logic [5:0]  degree;
    } t_row;

    t_row dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int slot_of(logic [63:0] id);
        for (int s = 0; s < MAX_NODES; s++)
            if (g_valid[s] && g_ids[s] == id) return s;
        return -1;
    endfunction

    // apply one transaction to the predictor, return its response
    function automatic t_rsp graph_apply(t_req r);
        int sa, sb, s;
        t_status st;
        t_rsp o;
        sa = slot_of(r.first_id);
        sb = slot_of(r.second_id);
        st = ST_BAD;
        case (r.mode)
            MODE_ADD_NODE: begin
                if (sa >= 0) st = ST_PRESENT;
                else if (g_count >= MAX_NODES) st = ST_FULL;
                else begin
                    for (s = 0; s < MAX_NODES && g_valid[s]; s++);
                    g_ids[s] = r.first_id; g_valid[s] = 1'b1;
                    g_deg[s] = 0; g_adj[s] = '0;
                    g_count++; sa = s; st = ST_OK;
                end
            end
            MODE_DEL_NODE: begin
                if (sa >= 0) begin
                    for (s = 0; s < MAX_NODES; s++)
                        if (g_valid[s] && g_adj[sa][s]) begin
                            g_adj[s][sa] = 1'b0;
                            if (g_deg[s] > 0) g_deg[s]--;
                        end
                    g_adj[sa] = '0; g_deg[sa] = 0; g_valid[sa] = 1'b0;
                    g_count--; sa = -1; st = ST_OK;
                end
            end
            MODE_GET_NODE: st = (sa >= 0) ? ST_NODE_FOUND : ST_NODE_ABSENT;
            MODE_ADD_EDGE, MODE_DEL_EDGE, MODE_GET_EDGE: begin
                if (r.first_id == r.second_id || sa < 0 || sb < 0) st = ST_BAD;
                else if (r.mode == MODE_ADD_EDGE) begin
                    if (g_adj[sa][sb]) st = ST_PRESENT;
                    else begin
                        g_adj[sa][sb] = 1'b1; g_adj[sb][sa] = 1'b1;
                        g_deg[sa]++; g_deg[sb]++; st = ST_OK;
                    end
                end else if (r.mode == MODE_DEL_EDGE) begin
                    if (g_adj[sa][sb]) begin
                        g_adj[sa][sb] = 1'b0; g_adj[sb][sa] = 1'b0;
                        g_deg[sa]--; g_deg[sb]--; st = ST_OK;
                    end
                end else st = g_adj[sa][sb] ? ST_EDGE_FOUND : ST_EDGE_ABSENT;
            end
            default: st = ST_BAD;
        endcase
        o.status = st;
        o.first_degree = (sa < 0) ? 6'd0 : (g_deg[sa] > 63 ? 6'd63 : 6'(g_deg[sa]));
        return o;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        err_count++;
    endtask

    // send one transaction, honoring stall; idles beforehand at random.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        rsp_queue.push_back(graph_apply(r));
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_id();
        case ($urandom_range(9))
            0:       return {$urandom, $urandom};
            1:       return ID_MAX;
            default: return id_pool[$urandom_range(15)];
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int k;
        k = $urandom_range(99);
        r.first_id  = pick_id();
        r.second_id = pick_id();
        if (k < 22)      r.mode = MODE_ADD_NODE;
        else if (k < 32) r.mode = MODE_DEL_NODE;
        else if (k < 40) r.mode = MODE_GET_NODE;
        else if (k < 70) r.mode = MODE_ADD_EDGE;
        else if (k < 82) r.mode = MODE_DEL_EDGE;
        else if (k < 95) r.mode = MODE_GET_EDGE;
        else             r.mode = 3'($urandom_range(7));
        return r;
    endfunction

    // response checker and receiver stalls
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_rsp_valid && !i_rsp_stall) begin
                if (rsp_queue.size() == 0) report_mismatch("response with none expected");
                else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (o_rsp.status !== exp_rsp.status)
                        report_mismatch($sformatf("status %0d exp %0d",
                                        o_rsp.status, exp_rsp.status));
                    if (o_rsp.first_degree !== exp_rsp.first_degree)
                        report_mismatch($sformatf("degree %0d exp %0d",
                                        o_rsp.first_degree, exp_rsp.first_degree));
                end
            end
        end
    end

    always @(negedge i_clk)
        i_rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    initial begin
        forever begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic void add_row(logic [2:0] m, logic [63:0] a, logic [63:0] b,
                                    bit fixed, t_status st, logic [5:0] d);
        t_row r;
        r.mode = m; r.a = a; r.b = b; r.check_fixed = fixed;
        r.status = st; r.degree = d;
        dir_rows.push_back(r);
    endfunction

    initial begin
        t_req r;
        i_rst_n = 1'b0; i_req_valid = 1'b0; i_req = '0; i_rsp_stall = 1'b0;
        err_count = 0; cycle_count = 0; send_idle_pct = 0; recv_idle_pct = 0;
        for (int s = 0; s < MAX_NODES; s++) begin
            g_ids[s] = '0; g_valid[s] = 1'b0; g_adj[s] = '0; g_deg[s] = 0;
        end
        g_count = 0;
        for (int k = 0; k < 16; k++) id_pool[k] = {$urandom, $urandom};
        id_pool[0] = 64'd0; id_pool[1] = ID_MAX; id_pool[2] = 64'h5555_5555_5555_5555;
        id_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, each mode and each special case
        add_row(MODE_GET_NODE, 64'd0, 64'd0, 1'b1, ST_NODE_ABSENT, 6'd0);
        add_row(MODE_DEL_NODE, ID_MAX, 64'd0, 1'b1, ST_BAD, 6'd0);
        add_row(MODE_ADD_NODE, 64'd0, 64'd0, 1'b1, ST_OK, 6'd0);
        add_row(MODE_ADD_NODE, 64'd0, 64'd0, 1'b1, ST_PRESENT, 6'd0);
        add_row(MODE_ADD_NODE, ID_MAX, 64'd0, 1'b1, ST_OK, 6'd0);
        add_row(MODE_ADD_EDGE, 64'd0, 64'd0, 1'b1, ST_BAD, 6'd0);
        add_row(MODE_ADD_EDGE, 64'd0, 64'd7, 1'b1, ST_BAD, 6'd0);
        add_row(MODE_ADD_EDGE, 64'd0, ID_MAX, 1'b1, ST_OK, 6'd1);
        add_row(MODE_ADD_EDGE, ID_MAX, 64'd0, 1'b1, ST_PRESENT, 6'd1);
        add_row(MODE_GET_EDGE, ID_MAX, 64'd0, 1'b1, ST_EDGE_FOUND, 6'd1);
        add_row(MODE_DEL_EDGE, 64'd0, ID_MAX, 1'b1, ST_OK, 6'd0);
        add_row(MODE_DEL_EDGE, 64'd0, ID_MAX, 1'b1, ST_BAD, 6'd0);
        add_row(MODE_GET_EDGE, 64'd0, ID_MAX, 1'b1, ST_EDGE_ABSENT, 6'd0);
        add_row(MODE_ADD_NODE, 64'h5555_5555_5555_5555, 64'd0, 1'b0, ST_OK, 6'd0);
        add_row(MODE_ADD_EDGE, 64'd0, 64'h5555_5555_5555_5555, 1'b0, ST_OK, 6'd0);
        add_row(MODE_ADD_EDGE, ID_MAX, 64'h5555_5555_5555_5555, 1'b0, ST_OK, 6'd0);
        add_row(MODE_DEL_NODE, 64'h5555_5555_5555_5555, 64'd0, 1'b0, ST_OK, 6'd0);
        add_row(MODE_GET_NODE, 64'd0, 64'd0, 1'b0, ST_OK, 6'd0);
        add_row(3'd6, 64'd0, ID_MAX, 1'b1, ST_BAD, 6'd0);
        add_row(3'd7, ID_MAX, 64'd0, 1'b1, ST_BAD, 6'd0);
        foreach (dir_rows[k]) begin
            t_rsp pred;
            r.mode = dir_rows[k].mode; r.first_id = dir_rows[k].a;
            r.second_id = dir_rows[k].b;
            send_req(r);
            pred = rsp_queue[$];
            if (dir_rows[k].check_fixed &&
                (pred.status != dir_rows[k].status || pred.first_degree != dir_rows[k].degree))
                report_mismatch($sformatf("directed row %0d predictor disagrees", k));
        end

        // fill the table to full, edge a hub to many nodes, then full add
        for (int k = 0; k < MAX_NODES; k++) begin
            r.mode = MODE_ADD_NODE; r.first_id = 64'h1000 + k; r.second_id = '0;
            send_req(r);
        end
        for (int k = 1; k < MAX_NODES; k++) begin
            r.mode = MODE_ADD_EDGE; r.first_id = 64'h1000;
            r.second_id = 64'h1000 + k;
            send_req(r);
        end
        r.mode = MODE_ADD_NODE; r.first_id = 64'hDEAD; send_req(r);
        // sender holds off until all responses are in
        i_req_valid <= 1'b0;
        do @(negedge i_clk); while (rsp_queue.size() != 0);
        r.mode = MODE_DEL_NODE; r.first_id = 64'h1000; send_req(r);
        for (int k = 1; k < MAX_NODES; k++) begin
            r.mode = MODE_DEL_NODE; r.first_id = 64'h1000 + k; send_req(r);
        end

        // random phases with differing idle mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 24 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) send_req(rand_req());
        end
        recv_idle_pct = 0;
        i_req_valid <= 1'b0;

        do @(negedge i_clk); while (rsp_queue.size() != 0);
        repeat (3 * MAX_NODES + 20) @(negedge i_clk);
        if (err_count == 0 && rsp_queue.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
